/* rtl/core/principal_curvature_rotation_top_assert.svh */
// Assertion macros for the principal curvature rotation block.
// Used by the top level; no other dependencies.
`ifndef PRINCIPAL_CURVATURE_ROTATION_TOP_ASSERT_SVH
`define PRINCIPAL_CURVATURE_ROTATION_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define PCR_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define PCR_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

/* rtl/core/pcr_pkg.sv */
// Package for the principal curvature rotation block: constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package pcr_pkg;
	localparam int CORDIC_STAGES = 24;
	localparam logic signed [63:0] ANG_HALF_PI = 64'sd1686629713;
	localparam logic signed [63:0] GAIN_INV_Q46 = 64'sd652032874 <<< 16;

	function automatic logic signed [63:0] atan_q30(input int i);
		logic signed [63:0] t [32];
		t = '{64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
			64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
			64'sd4194282, 64'sd2097149, 64'sd1048575, 64'sd524287,
			64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767,
			64'sd16383, 64'sd8191, 64'sd4095, 64'sd2047,
			64'sd1023, 64'sd511, 64'sd255, 64'sd127,
			64'sd63, 64'sd31, 64'sd15, 64'sd7, 64'sd3, 64'sd1, 64'sd0, 64'sd0};
		return t[i[4:0]];
	endfunction

	typedef struct packed {
		logic signed [31:0] ku;
		logic signed [31:0] kv;
		logic signed [31:0] kuv;
		logic               zero;
	} side_t;
endpackage

/* rtl/core/pcr_cordic.sv */
// CORDIC vectoring, half angle and rotation pipeline, one step per stage.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_cordic import pcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  side_t              in_side,
	output logic               out_valid,
	output side_t              out_side,
	output logic signed [31:0] cos_out,
	output logic signed [31:0] sin_out
);
	localparam int NC = 2 * CORDIC_STAGES + 4;
	logic               v_s [NC];
	side_t              d_s [NC];
	logic signed [63:0] x_s [NC];
	logic signed [63:0] y_s [NC];
	logic signed [63:0] z_s [NC];

	function automatic logic [6:0] lzs(input logic [63:0] m);
		logic [6:0] n;
		n = 7'd0;
		for (int k = 63; k >= 0; k--) begin
			if (m[k] && n == 7'd0) n = 7'(63 - k) + 7'd64;
		end
		return n;
	endfunction

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NC; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < NC; k++) v_s[k] <= v_s[k-1];
		end
	end

	// stage 0: build vector, quadrant turn
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [63:0] x, y;
			x = 64'(in_side.kv) - 64'(in_side.ku);
			y = -(64'(in_side.kuv) <<< 1);
			d_s[0] <= in_side;
			if (x < 0) begin
				if (y > 0) begin
					x_s[0] <= y; y_s[0] <= -x; z_s[0] <= ANG_HALF_PI;
				end else begin
					x_s[0] <= -y; y_s[0] <= x; z_s[0] <= -ANG_HALF_PI;
				end
			end else begin
				x_s[0] <= x; y_s[0] <= y; z_s[0] <= '0;
			end
		end
	end

	// stage 1: normalise so the larger magnitude reaches bit 59
	always_ff @(posedge clk) begin
		if (en) begin
			logic [63:0] mx, my, m;
			logic [6:0] n;
			logic [5:0] sh;
			mx = x_s[0][63] ? -x_s[0] : x_s[0];
			my = y_s[0][63] ? -y_s[0] : y_s[0];
			m = (mx > my) ? mx : my;
			n = lzs(m);
			sh = (n == 7'd0 || n[5:0] < 6'd4) ? 6'd0 : n[5:0] - 6'd4;
			d_s[1] <= d_s[0];
			x_s[1] <= x_s[0] <<< sh;
			y_s[1] <= y_s[0] <<< sh;
			z_s[1] <= z_s[0];
		end
	end

	// vectoring and rotation steps
	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[i+2] <= d_s[i+1];
				if (y_s[i+1] > 0) begin
					x_s[i+2] <= x_s[i+1] + (y_s[i+1] >>> i);
					y_s[i+2] <= y_s[i+1] - (x_s[i+1] >>> i);
					z_s[i+2] <= z_s[i+1] + atan_q30(i);
				end else begin
					x_s[i+2] <= x_s[i+1] - (y_s[i+1] >>> i);
					y_s[i+2] <= y_s[i+1] + (x_s[i+1] >>> i);
					z_s[i+2] <= z_s[i+1] - atan_q30(i);
				end
			end
		end
		localparam int R = CORDIC_STAGES + 3 + i;
		always_ff @(posedge clk) begin
			if (en) begin
				d_s[R] <= d_s[R-1];
				if (z_s[R-1] >= 0) begin
					x_s[R] <= x_s[R-1] - (y_s[R-1] >>> i);
					y_s[R] <= y_s[R-1] + (x_s[R-1] >>> i);
					z_s[R] <= z_s[R-1] - atan_q30(i);
				end else begin
					x_s[R] <= x_s[R-1] + (y_s[R-1] >>> i);
					y_s[R] <= y_s[R-1] - (x_s[R-1] >>> i);
					z_s[R] <= z_s[R-1] + atan_q30(i);
				end
			end
		end
	end

	// halve the angle and seed the rotation
	always_ff @(posedge clk) begin
		if (en) begin
			d_s[CORDIC_STAGES+2] <= d_s[CORDIC_STAGES+1];
			x_s[CORDIC_STAGES+2] <= GAIN_INV_Q46;
			y_s[CORDIC_STAGES+2] <= '0;
			z_s[CORDIC_STAGES+2] <= z_s[CORDIC_STAGES+1] >>> 1;
		end
	end

	// round to Q30 and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [63:0] c, s;
			c = (x_s[NC-2] + 64'sd32768) >>> 16;
			s = (y_s[NC-2] + 64'sd32768) >>> 16;
			if (c > 64'sd1073741824) c = 64'sd1073741824;
			if (c < -64'sd1073741824) c = -64'sd1073741824;
			if (s > 64'sd1073741824) s = 64'sd1073741824;
			if (s < -64'sd1073741824) s = -64'sd1073741824;
			d_s[NC-1] <= d_s[NC-2];
			x_s[NC-1] <= c;
			y_s[NC-1] <= s;
			z_s[NC-1] <= '0;
		end
	end

	assign out_valid = v_s[NC-1];
	assign out_side = d_s[NC-1];
	assign cos_out = x_s[NC-1][31:0];
	assign sin_out = y_s[NC-1][31:0];
endmodule

/* rtl/core/pcr_combine.sv */
// Squares, cross product and three-term sums with saturation, four stages; a zero twist passes ku and kv through.
// Depends on pcr_pkg.
`timescale 1ns / 1ps
module pcr_combine import pcr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  side_t              in_side,
	input  logic signed [31:0] cos_in,
	input  logic signed [31:0] sin_in,
	output logic               out_valid,
	output logic signed [31:0] k1,
	output logic signed [31:0] k2,
	output logic signed [31:0] c_out,
	output logic signed [31:0] s_out
);
	logic [3:0] v_q;
	side_t d_s1, d_s2, d_s3;
	logic signed [31:0] c_s1, s_s1, c_s2, s_s2, c_s3, s_s3;
	logic signed [63:0] c2_s1, s2_s1, cs_s1;
	logic signed [31:0] c2_s2, s2_s2, cs_s2;
	logic signed [63:0] a1_s3, b1_s3, e1_s3, a2_s3, b2_s3, e2_s3;
	logic signed [31:0] k1_s4, k2_s4, c_s4, s_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (en) v_q <= {v_q[2:0], in_valid};
	end

	// products and rounding to Q30, then curvature terms
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [63:0] r1, r2;
			d_s1 <= in_side; c_s1 <= cos_in; s_s1 <= sin_in;
			c2_s1 <= 64'(cos_in) * 64'(cos_in);
			s2_s1 <= 64'(sin_in) * 64'(sin_in);
			cs_s1 <= 64'(cos_in) * 64'(sin_in);
			d_s2 <= d_s1; c_s2 <= c_s1; s_s2 <= s_s1;
			c2_s2 <= 32'((c2_s1 + 64'sd536870912) >>> 30);
			s2_s2 <= 32'((s2_s1 + 64'sd536870912) >>> 30);
			cs_s2 <= 32'((cs_s1 + 64'sd536870912) >>> 30);
			d_s3 <= d_s2; c_s3 <= c_s2; s_s3 <= s_s2;
			a1_s3 <= 64'(d_s2.ku) * 64'(c2_s2);
			b1_s3 <= (64'(d_s2.kuv) * 64'(cs_s2)) <<< 1;
			e1_s3 <= 64'(d_s2.kv) * 64'(s2_s2);
			a2_s3 <= 64'(d_s2.ku) * 64'(s2_s2);
			b2_s3 <= (64'(d_s2.kuv) * 64'(cs_s2)) <<< 1;
			e2_s3 <= 64'(d_s2.kv) * 64'(c2_s2);
			r1 = (a1_s3 + b1_s3 + e1_s3 + 64'sd536870912) >>> 30;
			r2 = (a2_s3 - b2_s3 + e2_s3 + 64'sd536870912) >>> 30;
			if (r1 > 64'sd2147483647) r1 = 64'sd2147483647;
			if (r1 < -64'sd2147483648) r1 = -64'sd2147483648;
			if (r2 > 64'sd2147483647) r2 = 64'sd2147483647;
			if (r2 < -64'sd2147483648) r2 = -64'sd2147483648;
			if (d_s3.zero) begin
				k1_s4 <= d_s3.ku; k2_s4 <= d_s3.kv;
				c_s4 <= 32'sd1073741824; s_s4 <= '0;
			end else begin
				k1_s4 <= r1[31:0]; k2_s4 <= r2[31:0];
				c_s4 <= c_s3; s_s4 <= s_s3;
			end
		end
	end

	assign out_valid = v_q[3];
	assign k1 = k1_s4;
	assign k2 = k2_s4;
	assign c_out = c_s4;
	assign s_out = s_s4;
endmodule

/* rtl/core/principal_curvature_rotation_top.sv */
// Data passes through the CORDIC pipeline and then the product pipeline.
// One transaction per cycle while the output is free; the whole pipeline advances only then.
// A skid register on the input side keeps s_tready registered across a stall.
// Reset (arst_n low) clears all valid bits at once; data registers are not reset.
// Top level: depends on pcr_pkg, pcr_cordic, pcr_combine and the assertion header.
`timescale 1ns / 1ps
`include "principal_curvature_rotation_top_assert.svh"
module principal_curvature_rotation_top import pcr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // curv_u, curv_v, curv_twist
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // principal_one, principal_two, cos_angle, sin_angle
);
	logic en, cv, ov;
	side_t sd, cd;
	logic signed [31:0] cc, cs, k1, k2, co, so;
	logic skv_q;
	logic [95:0] skd_q;
	logic [95:0] pd;
	logic pv;

	// advance whenever the output slot is empty or being taken
	assign en = !m_tvalid || m_tready;
	assign s_tready = !skv_q;
	assign pv = skv_q || s_tvalid;
	assign pd = skv_q ? skd_q : s_tdata;

	// hold an input that arrives during a stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) skv_q <= 1'b0;
		else if (en) skv_q <= 1'b0;
		else if (s_tvalid && s_tready) skv_q <= 1'b1;
	end
	always_ff @(posedge clk) begin
		if (!en && s_tvalid && s_tready) skd_q <= s_tdata;
	end

	assign sd.ku = pd[31:0];
	assign sd.kv = pd[63:32];
	assign sd.kuv = pd[95:64];
	assign sd.zero = (pd[95:64] == 32'd0);

	pcr_cordic u_cordic (.clk, .arst_n, .en, .in_valid(pv), .in_side(sd),
		.out_valid(cv), .out_side(cd), .cos_out(cc), .sin_out(cs));
	pcr_combine u_comb (.clk, .arst_n, .en, .in_valid(cv), .in_side(cd),
		.cos_in(cc), .sin_in(cs), .out_valid(ov), .k1, .k2, .c_out(co), .s_out(so));

	assign m_tvalid = ov;
	assign m_tdata = {so, co, k2, k1};

	`PCR_ASSERT_IMP(a_skid_stall, skv_q, !s_tready)
	`PCR_ASSERT_NXT(a_skid_fill, !en && s_tvalid && s_tready, skv_q)
	`PCR_ASSERT_NXT(a_hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule
